// File: hw/rtl/vsd_pkg.sv
package vsd_pkg;

    // Field widths fixed by the stream format.
    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned INDEX_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned BYTES_W  = 4;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned BITPOS_W = 7;

    // Bit 7 of a code byte flags that more groups of the same value follow.
    localparam int unsigned CONT_BIT = 7;

    // Bit position saturates here during long runs of zero groups.
    localparam logic [BITPOS_W-1:0] BITPOS_CAP = 7'd70;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_WIDE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd3;

    // Configuration register indexes.
    localparam logic REG_VALUE_BYTES = 1'b0;
    localparam logic REG_VALUE_COUNT = 1'b1;

    typedef struct packed {
        logic [BYTES_W-1:0] value_bytes;
        logic [COUNT_W-1:0] value_count;
    } t_cfg;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [INDEX_W-1:0]  value_index;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

endpackage

// File: hw/rtl/vsd_byte_if.sv
interface vsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

// File: hw/rtl/vsd_result_if.sv
interface vsd_result_if;
    logic                                valid;
    logic                                ready;
    logic [vsd_pkg::VALUE_W-1:0]         value;
    logic [vsd_pkg::INDEX_W-1:0]         value_index;
    logic [vsd_pkg::STATUS_W-1:0]        status;
    logic                                last;

    modport source (output valid, output value, output value_index, output status,
                    output last, input ready);
    modport sink   (input valid, input value, input value_index, input status,
                    input last, output ready);
endinterface

// File: hw/rtl/vsd_cfg_regs.sv
module vsd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [vsd_pkg::COUNT_W-1:0]   i_cfg_wdata,
    output vsd_pkg::t_cfg                 o_cfg
);

    vsd_pkg::t_cfg r_cfg;

    // Register file write; each register keeps the low bits of the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.value_bytes <= 4'd8;
            r_cfg.value_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vsd_pkg::REG_VALUE_BYTES: begin
                    r_cfg.value_bytes <= i_cfg_wdata[vsd_pkg::BYTES_W-1:0];
                end
                vsd_pkg::REG_VALUE_COUNT: begin
                    r_cfg.value_count <= i_cfg_wdata;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/vsd_decode.sv
module vsd_decode #(
    parameter int MAX_VALUE_BYTES = 8,
    parameter int INDEX_BITS      = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_code_byte,
    input  logic                 i_stream_end,
    input  vsd_pkg::t_cfg        i_cfg,
    output logic                 o_res_valid,
    output vsd_pkg::t_result     o_res
);

    localparam int ACC_W  = MAX_VALUE_BYTES * 8;
    localparam int IDX_KW = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam logic [vsd_pkg::INDEX_W-1:0] IDX_MASK =
        vsd_pkg::INDEX_W'((17'd1 << IDX_KW) - 17'd1);

    logic [ACC_W-1:0]                  r_acc, n_acc;
    logic [vsd_pkg::BITPOS_W-1:0]      r_bitpos, n_bitpos;
    logic [vsd_pkg::COUNT_W-1:0]       r_counter, n_counter;
    logic                              r_discard, n_discard;

    logic [6:0]                        payload;
    logic                              cont;
    logic [vsd_pkg::BYTES_W-1:0]       nbytes;
    logic [6:0]                        width;
    logic [6:0]                        room;
    logic                              overflow;
    logic [ACC_W-1:0]                  acc_new;
    logic [7:0]                        bitpos_sum;
    logic [vsd_pkg::BITPOS_W-1:0]      bitpos_new;
    logic [vsd_pkg::INDEX_W-1:0]       index_now;

    assign payload = i_code_byte[6:0];
    assign cont    = i_code_byte[vsd_pkg::CONT_BIT];

    // Clamp the configured width to 1..MAX_VALUE_BYTES and convert to bits.
    always_comb begin
        if (i_cfg.value_bytes == '0) begin
            nbytes = 4'd1;
        end else if (i_cfg.value_bytes > vsd_pkg::BYTES_W'(MAX_VALUE_BYTES)) begin
            nbytes = vsd_pkg::BYTES_W'(MAX_VALUE_BYTES);
        end else begin
            nbytes = i_cfg.value_bytes;
        end
        width = {nbytes[3:0], 3'b000};
    end

    // A set payload bit at or above the value width is an overflow.
    always_comb begin
        room     = width - r_bitpos;
        overflow = 1'b0;
        if (payload != '0) begin
            if (r_bitpos >= width) begin
                overflow = 1'b1;
            end else if (room < 7'd7) begin
                overflow = (payload >> room[2:0]) != '0;
            end
        end
    end

    // Merge the new group; groups beyond the accumulator carry only zeros.
    assign acc_new    = r_acc | (ACC_W'(payload) << r_bitpos);
    assign bitpos_sum = {1'b0, r_bitpos} + 8'd7;
    assign bitpos_new = (bitpos_sum > {1'b0, vsd_pkg::BITPOS_CAP}) ?
                        vsd_pkg::BITPOS_CAP : bitpos_sum[6:0];
    assign index_now  = r_counter & IDX_MASK;

    // Per-byte decision: drop, error, finished value or partial value.
    always_comb begin
        n_acc             = r_acc;
        n_bitpos          = r_bitpos;
        n_counter         = r_counter;
        n_discard         = r_discard;
        o_res_valid       = 1'b0;
        o_res.value       = '0;
        o_res.value_index = index_now;
        o_res.status      = vsd_pkg::ST_OK;
        o_res.last        = i_stream_end;

        if (i_step) begin
            if (i_cfg.value_count == '0 || r_discard) begin
                if (i_stream_end) begin
                    n_acc     = '0;
                    n_bitpos  = '0;
                    n_counter = '0;
                    n_discard = 1'b0;
                end
            end else if (r_counter >= i_cfg.value_count || overflow || 
                         (cont && i_stream_end)) begin
                o_res_valid = 1'b1;
                if (r_counter >= i_cfg.value_count) begin
                    o_res.status = vsd_pkg::ST_TOO_MANY;
                end else if (overflow) begin
                    o_res.status = vsd_pkg::ST_TOO_WIDE;
                end else begin
                    o_res.status = vsd_pkg::ST_TRUNCATED;
                end
                n_acc    = '0;
                n_bitpos = '0;
                if (i_stream_end) begin
                    n_counter = '0;
                    n_discard = 1'b0;
                end else begin
                    n_discard = 1'b1;
                end
            end else if (!cont) begin
                o_res_valid = 1'b1;
                o_res.value = vsd_pkg::VALUE_W'(acc_new);
                n_acc       = '0;
                n_bitpos    = '0;
                n_counter   = i_stream_end ? '0 : r_counter + 16'd1;
            end else begin
                n_acc    = acc_new;
                n_bitpos = bitpos_new;
            end
        end
    end

    // Stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_bitpos  <= '0;
            r_counter <= '0;
            r_discard <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_bitpos  <= n_bitpos;
            r_counter <= n_counter;
            r_discard <= n_discard;
        end
    end

endmodule

// File: hw/rtl/varint_stream_decoder_core.sv
// Unsigned LEB128 varint stream decoder.
// Input channel i_byte carries one code byte per request with a stream_end
// flag on the last byte of a stream. Output channel o_result carries one
// decoded value (or an error report) per request with its index, a status
// code and a last flag. Bytes that continue a value, or that are dropped
// after an error, produce no result.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0: value width in bytes, 1: number of values expected); write only
// while the block is idle.
// Throughput: one byte per cycle unless o_result stalls, set by the single
// decode step between the input and result registers, which updates the
// stream state.
// Reset: the value width returns to 8 bytes, the count to 0, all stream
// state clears and both channels are empty.
// Stall: while a result waits, one more byte enters the input register;
// beyond that i_byte.ready drops until o_result.ready is seen.
module varint_stream_decoder_core #(
    parameter int MAX_VALUE_BYTES = 8,
    parameter int INDEX_BITS      = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [vsd_pkg::COUNT_W-1:0]  i_cfg_wdata,
    vsd_byte_if.sink                     i_byte,
    vsd_result_if.source                 o_result
);

    vsd_pkg::t_cfg    cfg;
    vsd_pkg::t_result res;
    logic             res_valid;
    logic             advance;
    logic             step;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_end;
    logic             r_out_valid;
    vsd_pkg::t_result r_out;

    vsd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // A held byte is decoded when the result register can take its output.
    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_byte.ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready) begin
            r_in_byte <= i_byte.code_byte;
            r_in_end  <= i_byte.stream_end;
        end
    end

    vsd_decode #(
        .MAX_VALUE_BYTES (MAX_VALUE_BYTES),
        .INDEX_BITS      (INDEX_BITS)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_code_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .i_cfg        (cfg),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.value       = r_out.value;
    assign o_result.value_index = r_out.value_index;
    assign o_result.status      = r_out.status;
    assign o_result.last        = r_out.last;

endmodule
